// ===== hdl/assert_macros.svh =====
// Assertion helpers for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, disabled while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("power limit forwarder assertion failed");

// Implication that must hold at every sampled edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   `ASSERT_CLK_RST(label, clk, rst, (cond) |-> (expr))

`endif

// ===== hdl/plcf_pkg.sv =====
package plcf_pkg;

   typedef enum logic [1:0] {
      OP_POLL      = 2'd0,
      OP_COMMAND   = 2'd1,
      OP_ECHO      = 2'd2,
      OP_ERROR     = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_MIN_WRITE_GAP = 2'd0,
      CSR_IDLE_REVERT   = 2'd1,
      CSR_TARGET_REG    = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;

   localparam logic [6:0]  PERCENT_FULL      = 7'd100;
   localparam logic [15:0] ROUND_FULL_TENTHS = 16'd995;
   localparam logic [7:0]  ACK_ECHO_LENGTH   = 8'd4;
   localparam logic [9:0]  ROUND_OFFSET      = 10'd5;
   // x / 10 == (x * 205) >> 11 for every x below 1029.
   localparam logic [7:0]  DIV10_RECIP       = 8'd205;
   localparam int          DIV10_SHIFT       = 11;

   localparam logic [15:0] GAP_RESET         = 16'd100;
   localparam logic [31:0] IDLE_RESET        = 32'd0;
   localparam logic [15:0] TARGET_RESET      = 16'd3;

   typedef struct packed {
      opcode_type  opcode;
      logic [31:0] now_ms;
      logic        bus_ready;
      logic [15:0] limit_tenths;
      logic        limit_enabled;
      logic [7:0]  echo_length;
   } req_item_type;

   typedef struct packed {
      logic        write_valid;
      logic [15:0] write_address;
      logic [6:0]  write_value;
      logic        applied_known;
      logic [6:0]  applied_percent;
      logic        awaiting_ack;
   } rsp_item_type;

endpackage

// ===== hdl/power_limit_command_forwarder_unit.sv =====
// Flow: an accepted item is held in the input register, and its result item is written
// into the result register when that register is empty or being read.
// Throughput: one item per cycle while the result side does not stall; each item is
// handled in a single pass of logic between the input register and the result register.
// Reset: synchronous, active high; clears both pipeline valids, the forwarder
// state and the three control registers to their documented defaults.
module power_limit_command_forwarder_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  plcf_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output plcf_pkg::rsp_item_type rsp_item,
   input  logic                  csr_write_enable,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_write_data
);

   // Control registers.
   logic [15:0] min_gap_ff;
   logic [31:0] idle_revert_ff;
   logic [15:0] target_reg_ff;

   // Input stage. The item is held here until the result register can take
   // its result, so a new item is accepted every cycle while results flow.
   logic                   in_valid_ff;
   plcf_pkg::req_item_type in_item_ff;

   // Result stage.
   logic                   rsp_valid_ff;
   plcf_pkg::rsp_item_type rsp_item_ff;
   plcf_pkg::rsp_item_type rsp_item_in;

   // Forwarder state. Each percent carries a flag in place of the "none" mark.
   logic        pend_valid_ff, pend_valid_in;
   logic [6:0]  pend_pct_ff, pend_pct_in;
   logic        infl_valid_ff, infl_valid_in;
   logic [6:0]  infl_pct_ff, infl_pct_in;
   logic        applied_known_ff, applied_known_in;
   logic [6:0]  applied_pct_ff, applied_pct_in;
   logic        expect_ack_ff, expect_ack_in;
   logic [31:0] last_cmd_time_ff, last_cmd_time_in;
   logic [31:0] last_write_time_ff, last_write_time_in;

   logic advance;

   // The input stage moves on when the result register is empty or being read.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_comb begin
      logic        full_scale;
      logic [9:0]  round_sum;
      logic [17:0] round_prod;
      logic [6:0]  cmd_pct;
      logic        idle_expired;
      logic        gap_passed;
      logic        wrote;
      logic [6:0]  write_pct;

      pend_valid_in      = pend_valid_ff;
      pend_pct_in        = pend_pct_ff;
      infl_valid_in      = infl_valid_ff;
      infl_pct_in        = infl_pct_ff;
      applied_known_in   = applied_known_ff;
      applied_pct_in     = applied_pct_ff;
      expect_ack_in      = expect_ack_ff;
      last_cmd_time_in   = last_cmd_time_ff;
      last_write_time_in = last_write_time_ff;
      wrote              = 1'b0;
      write_pct          = '0;

      // Command rounding: (tenths + 5) / 10, with full scale when disabled or
      // at least 99.5 percent. Below 995 the low ten bits hold the value.
      full_scale = !in_item_ff.limit_enabled ||
                   (in_item_ff.limit_tenths >= plcf_pkg::ROUND_FULL_TENTHS);
      round_sum  = in_item_ff.limit_tenths[9:0] + plcf_pkg::ROUND_OFFSET;
      round_prod = 18'(round_sum) * 18'(plcf_pkg::DIV10_RECIP);
      cmd_pct    = full_scale ? plcf_pkg::PERCENT_FULL
                              : round_prod[plcf_pkg::DIV10_SHIFT +: 7];

      idle_expired = (idle_revert_ff != 32'd0) && !expect_ack_ff &&
                     ((in_item_ff.now_ms - last_cmd_time_ff) >= idle_revert_ff);
      gap_passed   = (last_write_time_ff == 32'd0) ||
                     ((in_item_ff.now_ms - last_write_time_ff) >= {16'd0, min_gap_ff});

      unique case (in_item_ff.opcode)
         plcf_pkg::OP_POLL: begin
            // The idle timeout is settled first so that its 100 percent can go
            // out in the same poll.
            if (idle_expired) begin
               last_cmd_time_in = in_item_ff.now_ms;
               if (!(applied_known_ff && applied_pct_ff == plcf_pkg::PERCENT_FULL)) begin
                  pend_valid_in = 1'b1;
                  pend_pct_in   = plcf_pkg::PERCENT_FULL;
               end
            end
            if (pend_valid_in && !expect_ack_ff && in_item_ff.bus_ready && gap_passed) begin
               wrote              = 1'b1;
               write_pct          = pend_pct_in;
               pend_valid_in      = 1'b0;
               infl_valid_in      = 1'b1;
               infl_pct_in        = pend_pct_in;
               expect_ack_in      = 1'b1;
               last_write_time_in = in_item_ff.now_ms;
            end
         end
         plcf_pkg::OP_COMMAND: begin
            last_cmd_time_in = in_item_ff.now_ms;
            // A command equal to the acknowledged value is dropped.
            if (!(applied_known_ff && cmd_pct == applied_pct_ff)) begin
               pend_valid_in = 1'b1;
               pend_pct_in   = cmd_pct;
            end
         end
         plcf_pkg::OP_ECHO: begin
            if (expect_ack_ff && in_item_ff.echo_length == plcf_pkg::ACK_ECHO_LENGTH) begin
               expect_ack_in = 1'b0;
               if (infl_valid_ff) begin
                  applied_known_in = 1'b1;
                  applied_pct_in   = infl_pct_ff;
                  infl_valid_in    = 1'b0;
               end
            end
         end
         plcf_pkg::OP_ERROR: begin
            // An error response while a write is outstanding leaves the applied value unknown.
            if (expect_ack_ff) begin
               expect_ack_in    = 1'b0;
               infl_valid_in    = 1'b0;
               applied_known_in = 1'b0;
            end
         end
         default: begin
         end
      endcase

      rsp_item_in.write_valid     = wrote;
      rsp_item_in.write_address   = wrote ? target_reg_ff : 16'd0;
      rsp_item_in.write_value     = write_pct;
      rsp_item_in.applied_known   = applied_known_in;
      rsp_item_in.applied_percent = applied_known_in ? applied_pct_in : 7'd0;
      rsp_item_in.awaiting_ack    = expect_ack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_gap_ff         <= plcf_pkg::GAP_RESET;
         idle_revert_ff     <= plcf_pkg::IDLE_RESET;
         target_reg_ff      <= plcf_pkg::TARGET_RESET;
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         pend_valid_ff      <= 1'b0;
         pend_pct_ff        <= '0;
         infl_valid_ff      <= 1'b0;
         infl_pct_ff        <= '0;
         applied_known_ff   <= 1'b0;
         applied_pct_ff     <= '0;
         expect_ack_ff      <= 1'b0;
         last_cmd_time_ff   <= '0;
         last_write_time_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            case (plcf_pkg::csr_index_type'(csr_index))
               plcf_pkg::CSR_MIN_WRITE_GAP: min_gap_ff     <= csr_write_data[15:0];
               plcf_pkg::CSR_IDLE_REVERT:   idle_revert_ff <= csr_write_data;
               plcf_pkg::CSR_TARGET_REG:    target_reg_ff  <= csr_write_data[15:0];
               default: begin
               end
            endcase
         end

         if (!req_stall) begin
            in_valid_ff <= req_valid;
            in_item_ff  <= req_item;
         end

         if (advance) begin
            rsp_valid_ff       <= 1'b1;
            rsp_item_ff        <= rsp_item_in;
            pend_valid_ff      <= pend_valid_in;
            pend_pct_ff        <= pend_pct_in;
            infl_valid_ff      <= infl_valid_in;
            infl_pct_ff        <= infl_pct_in;
            applied_known_ff   <= applied_known_in;
            applied_pct_ff     <= applied_pct_in;
            expect_ack_ff      <= expect_ack_in;
            last_cmd_time_ff   <= last_cmd_time_in;
            last_write_time_ff <= last_write_time_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== hdl/plcf_checker.sv =====
`include "assert_macros.svh"

module plcf_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input plcf_pkg::rsp_item_type rsp_item
);

   // A stalled result item stays put.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset,
                   (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_item)))

   // Issuing a write always leaves it outstanding, with a percent in range.
   `ASSERT_IMPLIES(a_write_pending, clock, reset, rsp_valid && rsp_item.write_valid,
                   rsp_item.awaiting_ack && (rsp_item.write_value <= 7'd100))

   // Without a write, address and value read as zero.
   `ASSERT_IMPLIES(a_no_write_zero, clock, reset, rsp_valid && !rsp_item.write_valid,
                   (rsp_item.write_address == 16'd0) && (rsp_item.write_value == 7'd0))

   // The applied percent is zero when unknown and never above full scale.
   `ASSERT_IMPLIES(a_applied_range, clock, reset, rsp_valid,
                   (rsp_item.applied_percent <= 7'd100) &&
                   (rsp_item.applied_known || (rsp_item.applied_percent == 7'd0)))

endmodule

bind power_limit_command_forwarder_unit plcf_checker u_plcf_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam logic [7:0] NO_PERCENT = 8'd255;
   localparam logic [7:0] FULL_PCT8  = {1'b0, plcf_pkg::PERCENT_FULL};
   localparam logic [7:0] ACK_LEN    = plcf_pkg::ACK_ECHO_LENGTH;
   localparam int         LONG_HOLD  = 80;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   plcf_pkg::req_item_type req_item = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   plcf_pkg::rsp_item_type rsp_item;
   logic                   csr_write_enable = 1'b0;
   logic [1:0]             csr_index = plcf_pkg::CSR_MIN_WRITE_GAP;
   logic [31:0]            csr_write_data = '0;

   power_limit_command_forwarder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Items waiting to be offered, and the results they are predicted to give.
   plcf_pkg::req_item_type pending_req[$];
   plcf_pkg::rsp_item_type expected_rsp[$];
   int                     mismatch_count = 0;

   // When set, neither side idles at random.
   bit calm = 1'b0;
   // Each increment asks the result side for one long stall.
   int hold_requests = 0;
   int holds_served = 0;
   int hold_count = 0;

   // Forwarder state as the predictor sees it.
   logic [15:0] gap_ms;
   logic [31:0] revert_ms;
   logic [15:0] target_addr;
   logic [7:0]  pend_pct;
   logic [7:0]  infl_pct;
   logic [7:0]  applied_pct;
   logic        ack_wait;
   logic [31:0] last_cmd_ms;
   logic [31:0] last_wr_ms;

   // Stimulus time base and shaping.
   logic [31:0] sim_ms = '0;
   int          ms_step_max = 120;
   logic [15:0] last_tenths = '0;

   task automatic clear_forwarder_state();
      gap_ms      = plcf_pkg::GAP_RESET;
      revert_ms   = plcf_pkg::IDLE_RESET;
      target_addr = plcf_pkg::TARGET_RESET;
      pend_pct    = NO_PERCENT;
      infl_pct    = NO_PERCENT;
      applied_pct = NO_PERCENT;
      ack_wait    = 1'b0;
      last_cmd_ms = '0;
      last_wr_ms  = '0;
   endtask

   function automatic logic [7:0] rounded_percent(logic [15:0] tenths, logic enabled);
      if (!enabled || tenths >= plcf_pkg::ROUND_FULL_TENTHS)
         return FULL_PCT8;
      return 8'((17'(tenths) + 17'd5) / 17'd10);
   endfunction

   // Advances the predicted state by one item and returns the result it gives.
   function automatic plcf_pkg::rsp_item_type forward_limit(plcf_pkg::req_item_type it);
      plcf_pkg::rsp_item_type r;
      logic [7:0]             pct;
      logic [7:0]             wval;
      logic                   wrote;
      logic [31:0]            elapsed;
      wrote = 1'b0;
      wval = '0;
      case (it.opcode)
         plcf_pkg::OP_POLL: begin
            // The idle timeout is looked at before the write decision.
            elapsed = it.now_ms - last_cmd_ms;
            if (revert_ms != 0 && !ack_wait && elapsed >= revert_ms) begin
               last_cmd_ms = it.now_ms;
               if (applied_pct != FULL_PCT8)
                  pend_pct = FULL_PCT8;
            end
            elapsed = it.now_ms - last_wr_ms;
            // A last write time of zero reads as never written, so the gap is skipped.
            if (pend_pct != NO_PERCENT && !ack_wait && it.bus_ready &&
                (last_wr_ms == 0 || elapsed >= {16'd0, gap_ms})) begin
               wval       = pend_pct;
               pend_pct   = NO_PERCENT;
               infl_pct   = wval;
               ack_wait   = 1'b1;
               last_wr_ms = it.now_ms;
               wrote      = 1'b1;
            end
         end
         plcf_pkg::OP_COMMAND: begin
            pct = rounded_percent(it.limit_tenths, it.limit_enabled);
            last_cmd_ms = it.now_ms;
            if (!(applied_pct != NO_PERCENT && pct == applied_pct))
               pend_pct = pct;
         end
         plcf_pkg::OP_ECHO: begin
            if (ack_wait && it.echo_length == ACK_LEN) begin
               ack_wait = 1'b0;
               if (infl_pct != NO_PERCENT) begin
                  applied_pct = infl_pct;
                  infl_pct = NO_PERCENT;
               end
            end
         end
         default: begin
            if (ack_wait) begin
               ack_wait    = 1'b0;
               infl_pct    = NO_PERCENT;
               applied_pct = NO_PERCENT;
            end
         end
      endcase
      r.write_valid     = wrote;
      r.write_address   = wrote ? target_addr : 16'd0;
      r.write_value     = wrote ? wval[6:0] : 7'd0;
      r.applied_known   = (applied_pct != NO_PERCENT);
      r.applied_percent = (applied_pct != NO_PERCENT) ? applied_pct[6:0] : 7'd0;
      r.awaiting_ack    = ack_wait;
      return r;
   endfunction

   // Driver: offers queued items, holds a stalled item, and predicts each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_rsp.push_back(forward_limit(req_item));
         if (!req_valid || !req_stall) begin
            if (pending_req.size() > 0 && (calm || $urandom_range(0, 99) >= 10)) begin
               req_item  <= pending_req.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_result(plcf_pkg::rsp_item_type got);
      plcf_pkg::rsp_item_type want;
      if (expected_rsp.size() == 0) begin
         $error("result item with no expectation waiting");
         mismatch_count++;
         return;
      end
      want = expected_rsp.pop_front();
      if (got.write_valid !== want.write_valid) begin
         $error("write_valid: expected %0d, got %0d", want.write_valid, got.write_valid);
         mismatch_count++;
      end
      if (got.write_address !== want.write_address) begin
         $error("write_address: expected %0d, got %0d", want.write_address, got.write_address);
         mismatch_count++;
      end
      if (got.write_value !== want.write_value) begin
         $error("write_value: expected %0d, got %0d", want.write_value, got.write_value);
         mismatch_count++;
      end
      if (got.applied_known !== want.applied_known) begin
         $error("applied_known: expected %0d, got %0d", want.applied_known, got.applied_known);
         mismatch_count++;
      end
      if (got.applied_percent !== want.applied_percent) begin
         $error("applied_percent: expected %0d, got %0d",
                want.applied_percent, got.applied_percent);
         mismatch_count++;
      end
      if (got.awaiting_ack !== want.awaiting_ack) begin
         $error("awaiting_ack: expected %0d, got %0d", want.awaiting_ack, got.awaiting_ack);
         mismatch_count++;
      end
   endtask

   // Monitor: checks accepted results and drives the result-side stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_result(rsp_item);
         if (holds_served != hold_requests) begin
            holds_served++;
            hold_count = LONG_HOLD;
         end
         if (hold_count > 0) begin
            hold_count--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 10);
         end
      end
   end

   task automatic push_item(plcf_pkg::opcode_type op, logic [31:0] now, logic ready,
                            logic [15:0] tenths, logic enabled, logic [7:0] elen);
      plcf_pkg::req_item_type it;
      it.opcode        = op;
      it.now_ms        = now;
      it.bus_ready     = ready;
      it.limit_tenths  = tenths;
      it.limit_enabled = enabled;
      it.echo_length   = elen;
      pending_req.push_back(it);
   endtask

   // Waits until every queued item is accepted and every result has come, plus the latency.
   task automatic wait_drained();
      do
         @(posedge clock);
      while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(plcf_pkg::csr_index_type idx, logic [31:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         plcf_pkg::CSR_MIN_WRITE_GAP: gap_ms      = data[15:0];
         plcf_pkg::CSR_IDLE_REVERT:   revert_ms   = data;
         plcf_pkg::CSR_TARGET_REG:    target_addr = data[15:0];
         default: ;
      endcase
   endtask

   task automatic advance_ms();
      if ($urandom_range(0, 19) == 0)
         sim_ms = sim_ms + $urandom;
      else
         sim_ms = sim_ms + 32'($urandom_range(0, ms_step_max));
   endtask

   function automatic logic [15:0] pick_tenths();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2)
         return last_tenths;
      if (r < 6)
         return 16'($urandom_range(0, 1000));
      if (r < 8)
         return 16'($urandom_range(985, 1005));
      return 16'($urandom);
   endfunction

   // Mostly well-formed exchanges (command, polls, acknowledgement) with some noise.
   task automatic queue_random(int count);
      int made;
      int r;
      logic [15:0] tenths;
      made = 0;
      while (made < count) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            advance_ms();
            tenths = pick_tenths();
            last_tenths = tenths;
            push_item(plcf_pkg::OP_COMMAND, sim_ms, 1'($urandom), tenths,
                      $urandom_range(0, 7) != 0, 8'($urandom));
            made++;
            repeat ($urandom_range(1, 4)) begin
               advance_ms();
               push_item(plcf_pkg::OP_POLL, sim_ms, $urandom_range(0, 4) != 0,
                         16'($urandom), 1'($urandom), 8'($urandom));
               made++;
            end
            advance_ms();
            r = $urandom_range(0, 9);
            if (r < 7)
               push_item(plcf_pkg::OP_ECHO, sim_ms, 1'($urandom), 16'($urandom),
                         1'($urandom), ACK_LEN);
            else if (r < 8)
               push_item(plcf_pkg::OP_ECHO, sim_ms, 1'($urandom), 16'($urandom),
                         1'($urandom), 8'($urandom));
            else
               push_item(plcf_pkg::OP_ERROR, sim_ms, 1'($urandom), 16'($urandom),
                         1'($urandom), 8'($urandom));
            made++;
         end else if (r < 85) begin
            // A run of polls lets the idle timeout come due.
            repeat ($urandom_range(1, 5)) begin
               advance_ms();
               push_item(plcf_pkg::OP_POLL, sim_ms, 1'($urandom), 16'($urandom),
                         1'($urandom), 8'($urandom));
               made++;
            end
         end else begin
            advance_ms();
            push_item(plcf_pkg::opcode_type'($urandom_range(0, 3)),
                      ($urandom_range(0, 3) == 0) ? 32'($urandom) : sim_ms,
                      1'($urandom), 16'($urandom), 1'($urandom), 8'($urandom));
            made++;
         end
      end
   endtask

   initial begin
      clear_forwarder_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings: gap 100, no idle timeout, address 3.
      push_item(plcf_pkg::OP_ECHO, 32'd0, 1'b1, 16'd0, 1'b0, ACK_LEN);  // nothing outstanding
      push_item(plcf_pkg::OP_ERROR, 32'd0, 1'b1, 16'd0, 1'b0, 8'd0);    // nothing outstanding
      push_item(plcf_pkg::OP_POLL, 32'd0, 1'b1, 16'd0, 1'b0, 8'd0);     // nothing pending
      push_item(plcf_pkg::OP_COMMAND, 32'd0, 1'b0, 16'd0, 1'b1, 8'd0);
      push_item(plcf_pkg::OP_POLL, 32'd0, 1'b1, 16'd0, 1'b0, 8'd0);     // write at time zero
      push_item(plcf_pkg::OP_ECHO, 32'd1, 1'b0, 16'd0, 1'b0, 8'd3);     // wrong length
      push_item(plcf_pkg::OP_ECHO, 32'd1, 1'b0, 16'd0, 1'b0, ACK_LEN);
      push_item(plcf_pkg::OP_COMMAND, 32'd2, 1'b0, 16'd4, 1'b1, 8'd0);  // same as applied
      push_item(plcf_pkg::OP_POLL, 32'd3, 1'b1, 16'd0, 1'b0, 8'd0);
      push_item(plcf_pkg::OP_COMMAND, 32'd4, 1'b0, 16'd994, 1'b1, 8'd0);
      push_item(plcf_pkg::OP_POLL, 32'd5, 1'b0, 16'd0, 1'b0, 8'd0);     // bus not ready
      push_item(plcf_pkg::OP_POLL, 32'd5, 1'b1, 16'd0, 1'b0, 8'd0);     // gap ignored
      push_item(plcf_pkg::OP_COMMAND, 32'd6, 1'b0, 16'd995, 1'b1, 8'd0); // while outstanding
      push_item(plcf_pkg::OP_POLL, 32'd7, 1'b1, 16'd0, 1'b0, 8'd0);
      push_item(plcf_pkg::OP_ERROR, 32'd8, 1'b1, 16'd0, 1'b0, 8'd0);
      push_item(plcf_pkg::OP_POLL, 32'd50, 1'b1, 16'd0, 1'b0, 8'd0);    // gap not yet passed
      push_item(plcf_pkg::OP_POLL, 32'd105, 1'b1, 16'd0, 1'b0, 8'd0);
      push_item(plcf_pkg::OP_ECHO, 32'd106, 1'b0, 16'd0, 1'b0, 8'd255);
      push_item(plcf_pkg::OP_ECHO, 32'd106, 1'b0, 16'd0, 1'b0, ACK_LEN);
      push_item(plcf_pkg::OP_COMMAND, 32'd107, 1'b0, 16'd65535, 1'b1, 8'd0);
      push_item(plcf_pkg::OP_COMMAND, 32'd108, 1'b0, 16'd300, 1'b0, 8'd0); // disabled
      push_item(plcf_pkg::OP_COMMAND, 32'd109, 1'b0, 16'd5, 1'b1, 8'd0);
      push_item(plcf_pkg::OP_POLL, 32'hFFFF_FFFF, 1'b1, 16'd0, 1'b0, 8'd0);
      push_item(plcf_pkg::OP_ECHO, 32'hFFFF_FFFF, 1'b0, 16'd0, 1'b0, ACK_LEN);
      push_item(plcf_pkg::OP_COMMAND, 32'hFFFF_FFF0, 1'b0, 16'd15, 1'b1, 8'd0);
      push_item(plcf_pkg::OP_POLL, 32'h0000_0010, 1'b1, 16'd0, 1'b0, 8'd0);  // wraps, too soon
      push_item(plcf_pkg::OP_POLL, 32'd200, 1'b1, 16'd0, 1'b0, 8'd0);
      push_item(plcf_pkg::OP_ECHO, 32'd201, 1'b0, 16'd0, 1'b0, ACK_LEN);
      sim_ms = 32'd300;
      wait_drained();

      // Extremes at the low end of the gap, full address, no idling on either side.
      calm = 1'b1;
      write_csr(plcf_pkg::CSR_MIN_WRITE_GAP, 32'd0);
      write_csr(plcf_pkg::CSR_IDLE_REVERT, 32'd0);
      write_csr(plcf_pkg::CSR_TARGET_REG, 32'h0000_FFFF);
      write_csr(plcf_pkg::CSR_UNUSED, $urandom);
      ms_step_max = 50;
      queue_random(120);
      wait_drained();
      calm = 1'b0;

      // Extremes at the high end, with long time steps so writes still happen.
      write_csr(plcf_pkg::CSR_MIN_WRITE_GAP, 32'h0000_FFFF);
      write_csr(plcf_pkg::CSR_IDLE_REVERT, 32'hFFFF_FFFF);
      write_csr(plcf_pkg::CSR_TARGET_REG, 32'd0);
      ms_step_max = 70000;
      queue_random(100);
      wait_drained();

      // Short gap and timeout: the timeout fires often.
      write_csr(plcf_pkg::CSR_MIN_WRITE_GAP, 32'd10);
      write_csr(plcf_pkg::CSR_IDLE_REVERT, 32'd50);
      write_csr(plcf_pkg::CSR_TARGET_REG, 32'($urandom_range(0, 65535)));
      ms_step_max = 30;
      advance_ms();
      push_item(plcf_pkg::OP_COMMAND, sim_ms, 1'b1, 16'd500, 1'b1, 8'd0);
      push_item(plcf_pkg::OP_POLL, sim_ms + 32'd1, 1'b1, 16'd0, 1'b0, 8'd0);
      // Awaiting the acknowledgement, so no timeout.
      push_item(plcf_pkg::OP_POLL, sim_ms + 32'd60, 1'b1, 16'd0, 1'b0, 8'd0);
      push_item(plcf_pkg::OP_ECHO, sim_ms + 32'd61, 1'b1, 16'd0, 1'b0, ACK_LEN);
      push_item(plcf_pkg::OP_POLL, sim_ms + 32'd49, 1'b1, 16'd0, 1'b0, 8'd0);
      // The timeout reverts to full scale.
      push_item(plcf_pkg::OP_POLL, sim_ms + 32'd62, 1'b1, 16'd0, 1'b0, 8'd0);
      push_item(plcf_pkg::OP_ECHO, sim_ms + 32'd63, 1'b1, 16'd0, 1'b0, ACK_LEN);
      // Already at full scale.
      push_item(plcf_pkg::OP_POLL, sim_ms + 32'd120, 1'b1, 16'd0, 1'b0, 8'd0);
      sim_ms = sim_ms + 32'd130;
      queue_random(75);
      // The result side holds off for a long stretch while items keep coming.
      hold_requests++;
      wait_drained();
      queue_random(75);
      wait_drained();

      // Middle-of-range settings.
      write_csr(plcf_pkg::CSR_MIN_WRITE_GAP, 32'($urandom_range(0, 300)));
      write_csr(plcf_pkg::CSR_IDLE_REVERT, 32'($urandom_range(0, 400)));
      write_csr(plcf_pkg::CSR_TARGET_REG, 32'($urandom_range(0, 65535)));
      ms_step_max = 100;
      queue_random(130);
      wait_drained();

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
